// File: design/aidr_pkg.sv
// ----------------------------------------------------------------------------
// aidr_pkg
// Shared types, register codes and the exp2 constant table for the analog
// input deadzone and key repeat block.
// ----------------------------------------------------------------------------
package aidr_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_DIV,
        S_LOGSET,
        S_LOG,
        S_CMUL,
        S_EXP,
        S_SHIFT,
        S_CNT,
        S_MOD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        REG_INNER    = 3'd0,
        REG_OUTER    = 3'd1,
        REG_CURVE    = 3'd2,
        REG_THRESH   = 3'd3,
        REG_DELAY    = 3'd4,
        REG_INTERVAL = 3'd5
    } t_reg_idx;

    typedef logic [15:0][30:0] t_ctab;

    localparam logic [16:0] C_FULL      = 17'd32768;
    localparam logic [15:0] C_FULL16    = 16'd32768;
    localparam logic [15:0] C_MIN_SPAN  = 16'd328;
    localparam logic [30:0] C_ONE_Q30   = 31'h4000_0000;

    // floor square root, bit by bit
    function automatic logic [63:0] f_isqrt(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = 64'd0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // successive square roots of 0.5 in Q1.30
    function automatic t_ctab f_exp_table();
        t_ctab       tab;
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int k = 0; k < 16; k++) begin
            c      = f_isqrt(c << 30);
            tab[k] = c[30:0];
        end
        return tab;
    endfunction

    localparam t_ctab C_TAB = f_exp_table();

endpackage

// File: design/analog_input_deadzone_repeat.sv
// ----------------------------------------------------------------------------
// analog_input_deadzone_repeat
// Axis or button conditioning with deadzone, power curve and key repeat.
// ----------------------------------------------------------------------------
// Each input beat is one tick of one channel: an axis sample (or a button
// level) plus a key override. The block turns it into a Q1.15 level, applies
// the inner/outer deadzone, raises it to the Q4.12 curve power and updates a
// saturating per-channel tick counter, giving held/pressed/released/repeat.
// Channels: s_axis input (tready high only when idle), m_axis result with one
// output register, APB port for the six registers at 4*index.
// One item is worked on at a time: the next beat is taken only once the
// current one has passed the final step and the block is back in idle. The
// work runs through the bit-serial deadzone divider (15 steps), the shared
// 31x31 multiplier used for 16 log2 squarings and 16 exp2 products, and the
// 15-step repeat modulo.
// A finished result waits in the output register while the next beat is
// taken; the final step stalls only if that register is still full.
// Reset clears the registers to their defaults and marks every counter entry
// as zero (valid bits), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module analog_input_deadzone_repeat
    import aidr_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // channel[3:0], axis_sample[19:4], button_down[20], key_down[21], zero pad
    input  logic [23:0] i_s_axis_tdata,
    // take_negative[0], is_digital[1]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // channel_out[3:0], analog_level[19:4], is_held[20], just_pressed[21],
    // just_released[22], repeat_pulse[23], tick_count[39:24]
    output logic [39:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IW = (AW > 4) ? AW : 4;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_inner, r_outer, r_curve, r_thresh;
    logic [14:0] r_delay, r_interval;
    logic        w_cfg_wr;
    t_reg_idx    w_cfg_idx;

    // captured beat
    logic [15:0] r_sample;
    logic        r_neg, r_dig, r_btn, r_key, r_ch_ok;
    logic [3:0]  r_ch;
    logic [AW-1:0] r_addr;
    logic [15:0] r_rd_cnt;
    logic        r_rd_vld;

    // counter store
    logic [15:0] r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;

    // datapath
    logic [4:0]  r_step;
    logic [15:0] r_factor;
    logic [16:0] r_rem;
    logic [14:0] r_q;
    logic        r_dz_zero, r_dz_full;
    logic [15:0] r_d;
    logic [3:0]  r_e;
    logic [30:0] r_m;
    logic [15:0] r_frac;
    logic [23:0] r_nq;
    logic [15:0] r_g;
    logic [30:0] r_r;
    logic [15:0] r_level;
    logic        r_held;
    logic [15:0] r_cnt;
    logic [14:0] r_mdiff, r_mrem;

    // output register
    logic        r_ovld;
    logic [39:0] r_odata;

    logic w_in_acc, w_out_acc;
    logic [IW-1:0] w_ch_ext;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_ovld && i_m_axis_tready;
    assign w_ch_ext  = IW'(i_s_axis_tdata[3:0]);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner    <= 16'd0;
            r_outer    <= 16'd0;
            r_curve    <= 16'd4096;
            r_thresh   <= 16'd16384;
            r_delay    <= 15'd20;
            r_interval <= 15'd5;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_INNER:    r_inner    <= pwdata[15:0];
                REG_OUTER:    r_outer    <= pwdata[15:0];
                REG_CURVE:    r_curve    <= pwdata[15:0];
                REG_THRESH:   r_thresh   <= pwdata[15:0];
                REG_DELAY:    r_delay    <= pwdata[14:0];
                REG_INTERVAL: r_interval <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_INNER:    prdata = {16'd0, r_inner};
            REG_OUTER:    prdata = {16'd0, r_outer};
            REG_CURVE:    prdata = {16'd0, r_curve};
            REG_THRESH:   prdata = {16'd0, r_thresh};
            REG_DELAY:    prdata = {17'd0, r_delay};
            REG_INTERVAL: prdata = {17'd0, r_interval};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- combinational helpers ----------------
    logic [16:0]        w_raw;
    logic [14:0]        w_pos;
    logic signed [17:0] w_span, w_num;
    logic [15:0]        w_span_c;
    logic [16:0]        w_rem2;
    logic [15:0]        w_dval;
    logic [3:0]         w_e;
    logic [30:0]        w_mset;
    logic [30:0]        w_mul_a, w_mul_b;
    logic [61:0]        w_prod;
    logic [31:0]        w_sq;
    logic [19:0]        w_neglog;
    logic [35:0]        w_nprod;
    logic [8:0]         w_shamt;
    logic [39:0]        w_rsum, w_rsh;
    logic [15:0]        w_pow, w_level;
    logic signed [15:0] w_c0, w_nc;
    logic [14:0]        w_iv;
    logic [15:0]        w_mrem2;
    logic [15:0]        w_diff;
    logic               w_rep;

    always_comb begin
        // raw level; s + (s >= 16384) equals the rounded 32768/32767 scaling
        w_pos = r_sample[15] ? 15'd0 : r_sample[14:0];
        if (r_key) begin
            w_raw = C_FULL;
        end else if (r_dig) begin
            w_raw = r_btn ? C_FULL : 17'd0;
        end else if (r_neg) begin
            w_raw = r_sample[15] ? 17'(-$signed({r_sample[15], r_sample})) : 17'd0;
        end else begin
            w_raw = {2'b0, w_pos} + {16'd0, w_pos[14]};
        end
        w_span   = 18'sd32768 - $signed({2'b0, r_outer}) - $signed({2'b0, r_inner});
        w_span_c = (w_span < 18'sd328) ? C_MIN_SPAN : w_span[15:0];
        w_num    = $signed({1'b0, w_raw}) - $signed({2'b0, r_inner});
        w_rem2   = {r_rem[15:0], 1'b0};

        w_dval = r_dz_zero ? 16'd0 : (r_dz_full ? C_FULL16 : {1'b0, r_q});
        w_e = 4'd0;
        for (int i = 1; i < 15; i++) begin
            if (w_dval[i]) w_e = 4'(i);
        end
        w_mset = 31'(w_dval) << (5'd30 - {1'b0, w_e});

        // one multiplier shared by the log squarings and exp products
        w_mul_a = (r_state == S_LOG) ? r_m : r_r;
        w_mul_b = (r_state == S_LOG) ? r_m : C_TAB[r_step[3:0]];
        w_prod  = 62'(w_mul_a) * 62'(w_mul_b);
        w_sq    = w_prod[61:30];

        w_neglog = {4'd15 - r_e, 16'd0} - {4'd0, r_frac};
        w_nprod  = 36'(w_neglog) * 36'(r_curve) + 36'd2048;

        w_shamt = 9'd15 + {1'b0, r_nq[23:16]};
        w_rsum  = 40'(r_r) + (40'd1 << (w_shamt[5:0] - 6'd1));
        w_rsh   = w_rsum >> w_shamt[5:0];
        if (w_shamt >= 9'd40) begin
            w_pow = 16'd0;
        end else if (w_rsh > 40'd32768) begin
            w_pow = C_FULL16;
        end else begin
            w_pow = w_rsh[15:0];
        end
        if (r_curve == 16'd0 || r_d == C_FULL16) begin
            w_level = C_FULL16;
        end else if (r_d == 16'd0) begin
            w_level = 16'd0;
        end else begin
            w_level = w_pow;
        end

        // saturating tick counter
        w_c0 = r_rd_vld ? $signed(r_rd_cnt) : 16'sd0;
        if (r_held) begin
            if (w_c0 < 16'sd0) w_c0 = 16'sd0;
            w_nc = (w_c0 == 16'sd32767) ? w_c0 : w_c0 + 16'sd1;
        end else begin
            if (w_c0 > 16'sd0) w_c0 = 16'sd0;
            w_nc = (w_c0 == -16'sd32768) ? w_c0 : w_c0 - 16'sd1;
        end
        w_diff = w_nc - $signed({1'b0, r_delay});

        w_iv    = (r_interval == 15'd0) ? 15'd1 : r_interval;
        w_mrem2 = {r_mrem, r_mdiff[14]};

        w_rep = r_ch_ok && ((r_cnt == 16'd1) ||
                (($signed(r_cnt) >= $signed({1'b0, r_delay})) && (r_mrem == 15'd0)));
    end

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_axis_tvalid) n_state = S_RAW;
            S_RAW:    n_state = S_DIV;
            S_DIV:    if (r_step == 5'd14) n_state = S_LOGSET;
            S_LOGSET: n_state = S_LOG;
            S_LOG:    if (r_step == 5'd15) n_state = S_CMUL;
            S_CMUL:   n_state = S_EXP;
            S_EXP:    if (r_step == 5'd15) n_state = S_SHIFT;
            S_SHIFT:  n_state = S_CNT;
            S_CNT:    n_state = S_MOD;
            S_MOD:    if (r_step == 5'd14) n_state = S_DONE;
            S_DONE:   if (!r_ovld || i_m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = r_ovld;
        o_m_axis_tdata  = r_odata;
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ch     <= i_s_axis_tdata[3:0];
                r_sample <= i_s_axis_tdata[19:4];
                r_btn    <= i_s_axis_tdata[20];
                r_key    <= i_s_axis_tdata[21];
                r_neg    <= i_s_axis_tuser[0];
                r_dig    <= i_s_axis_tuser[1];
                r_addr   <= w_ch_ext[AW-1:0];
                r_ch_ok  <= {1'b0, w_ch_ext} < (IW + 1)'(NUM_CHANNELS);
            end
            S_RAW: begin
                r_factor  <= w_span_c;
                r_dz_zero <= (w_num <= 18'sd0);
                r_dz_full <= (w_num >= $signed({2'b0, w_span_c}));
                r_rem     <= {1'b0, w_num[15:0]};
                r_q       <= 15'd0;
                r_step    <= 5'd0;
            end
            S_DIV: begin
                if (w_rem2 >= {1'b0, r_factor}) begin
                    r_rem <= w_rem2 - {1'b0, r_factor};
                    r_q   <= {r_q[13:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_q   <= {r_q[13:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
            end
            S_LOGSET: begin
                r_d    <= w_dval;
                r_e    <= w_e;
                r_m    <= w_mset;
                r_frac <= 16'd0;
                r_step <= 5'd0;
            end
            S_LOG: begin
                // square, then renormalise to [1,2) with one fraction bit out
                if (w_sq[31]) begin
                    r_m    <= w_sq[31:1];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= w_sq[30:0];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
            end
            S_CMUL: begin
                r_nq   <= w_nprod[35:12];
                r_g    <= w_nprod[27:12];
                r_r    <= C_ONE_Q30;
                r_step <= 5'd0;
            end
            S_EXP: begin
                if (r_g[15]) r_r <= w_prod[60:30];
                r_g    <= {r_g[14:0], 1'b0};
                r_step <= r_step + 5'd1;
            end
            S_SHIFT: begin
                r_level <= w_level;
                r_held  <= (w_level >= r_thresh);
            end
            S_CNT: begin
                r_cnt   <= r_ch_ok ? w_nc : 16'd0;
                r_mdiff <= w_diff[14:0];
                r_mrem  <= 15'd0;
                r_step  <= 5'd0;
            end
            S_MOD: begin
                if (w_mrem2 >= {1'b0, w_iv}) r_mrem <= 15'(w_mrem2 - {1'b0, w_iv});
                else                         r_mrem <= w_mrem2[14:0];
                r_mdiff <= {r_mdiff[13:0], 1'b0};
                r_step  <= r_step + 5'd1;
            end
            default: ;
        endcase
    end

    // counter store, registered read at the accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_rd_cnt <= r_mem[w_ch_ext[AW-1:0]];
        if (r_state == S_CNT && r_ch_ok) r_mem[r_addr] <= w_nc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_in_acc) r_rd_vld <= r_valid[w_ch_ext[AW-1:0]];
            if (r_state == S_CNT && r_ch_ok) r_valid[r_addr] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovld || i_m_axis_tready)) begin
            r_ovld <= 1'b1;
        end else if (w_out_acc) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovld || i_m_axis_tready)) begin
            r_odata <= {r_cnt, w_rep, (r_cnt == 16'hFFFF), (r_cnt == 16'd1),
                        ($signed(r_cnt) > 16'sd0), r_level, r_ch};
        end
    end

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_RAW)
        else $error("accepted beat did not start processing");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_odata[19:4] <= C_FULL16)
        else $error("level above full scale");

    a_press_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !(r_odata[21] && r_odata[22]))
        else $error("pressed and released together");

    a_no_store_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT && !r_ch_ok) |=> $stable(r_valid))
        else $error("counter store touched for channel without entry");

endmodule
